@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RMSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RMSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rmsp_pkg.sv @@
// ---------------------------------------------------------------------------
// rmsp_pkg
// shared types and constants of the rmsprop weight update engine
// ---------------------------------------------------------------------------
package rmsp_pkg;

  localparam int HIDDEN_UNITS = 64;
  localparam int INPUT_LEN    = 128;
  localparam int ENTRY_COUNT  = HIDDEN_UNITS * INPUT_LEN + HIDDEN_UNITS;

  localparam int IDX_W   = 14;
  localparam int VAL_W   = 32;
  localparam int LR_W    = 24;
  localparam int DECAY_W = 16;
  localparam int CFG_W   = 24;

  // 1e-5 in q.24
  localparam logic [28:0] EPS_Q24 = 29'd168;

  localparam int ROOT_W = 28;  // sqrt of a 56 bit operand
  localparam int NUM_W  = 57;  // dividend lr*|g| + den/2
  localparam int DEN_W  = 29;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ACCUM  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_LEARN_RATE = 1'b0,
    REG_DECAY      = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SQ,
    ST_MIX,
    ST_CSAT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

@@ hdl/rmsprop_weight_update.sv @@
// ---------------------------------------------------------------------------
// rmsprop_weight_update
// per-entry weight, gradient and rmsprop cache store with fixed point update
// ---------------------------------------------------------------------------
//  channel  ports                                      direction
//  in       in_valid in_stall in_cmd in_entry_index    beat in
//           in_value
//  out      out_valid out_stall out_weight_out         beat out
//           out_cache_out out_saturated
//  cfg      cfg_wr_en cfg_index cfg_wdata               register write
//
//  load, accumulate, read: from in beat to out beat through read, act and out
//  update: runs the bit-serial square root (28 steps), then
//  the one-bit-per-cycle divider (57 steps)
//  reset: a clearing pass over all 8256 rows zeroes gradients and caches, in_stall
//  stays high meanwhile; cfg writes are taken as ever
//  a new in beat is taken while a finished result waits on out_stall
// ---------------------------------------------------------------------------
module rmsprop_weight_update (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [rmsp_pkg::IDX_W-1:0]    in_entry_index,
  input  logic signed [rmsp_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rmsp_pkg::VAL_W-1:0] out_weight_out,
  output logic [rmsp_pkg::VAL_W-1:0]    out_cache_out,
  output logic                          out_saturated,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [rmsp_pkg::CFG_W-1:0]    cfg_wdata
);
  import rmsp_pkg::*;

  localparam logic [IDX_W:0]   ENTRY_LIM = (IDX_W+1)'(ENTRY_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRY_COUNT - 1);

  // config registers
  logic [LR_W-1:0]    lr_r;
  logic [DECAY_W-1:0] decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= 24'd1678;
      decay_r <= 16'd64881;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEARN_RATE: lr_r    <= cfg_wdata[LR_W-1:0];
        REG_DECAY:      decay_r <= cfg_wdata[DECAY_W-1:0];
        default:        ;
      endcase
    end
  end

  // state memories: weights, and gradient/cache rows {grad, cache}
  logic [VAL_W-1:0]   wmem  [ENTRY_COUNT];
  logic [2*VAL_W-1:0] gcmem [ENTRY_COUNT];

  logic               w_we;
  logic [VAL_W-1:0]   w_wdata;
  logic               gc_we;
  logic [IDX_W-1:0]   gc_addr;
  logic [2*VAL_W-1:0] gc_wdata;
  logic               rd_en;
  logic [VAL_W-1:0]   rd_w_r;
  logic [2*VAL_W-1:0] rd_gc_r;

  // control
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             in_beat;
  logic             in_oor;
  logic             out_free;

  // item registers
  cmd_t             cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;

  // update datapath
  logic [VAL_W-1:0] cur_w_r;
  logic [VAL_W-1:0] cur_c_r;
  logic [VAL_W-1:0] mag_r;
  logic             neg_r;
  logic [63:0]      sq_r;
  logic [57:0]      sum_r;
  logic [VAL_W-1:0] cnew_r;
  logic [55:0]      num_r;
  logic             sat_r;

  // result holding registers
  logic [VAL_W-1:0] res_w_r;
  logic [VAL_W-1:0] res_c_r;
  logic             res_s_r;

  // output register
  logic             out_valid_r;
  logic [VAL_W-1:0] out_w_r;
  logic [VAL_W-1:0] out_c_r;
  logic             out_s_r;

  // units
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] root;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  quot;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  numer;

  // combinational helpers
  logic [32:0]      gsum;
  logic [VAL_W-1:0] gnew;
  logic             gsat;
  logic [63:0]      sq_rnd;
  logic [38:0]      gsq;
  logic [16:0]      dcomp;
  logic [57:0]      csum;
  logic [58:0]      delta;
  logic [58:0]      wsum;
  logic [VAL_W-1:0] wnew;
  logic             wsat;

  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign in_oor   = {1'b0, in_entry_index} >= ENTRY_LIM;
  assign rd_en    = in_beat && !in_oor;
  assign out_free = !out_valid_r || !out_stall;

  // memories, registered read
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[idx_r] <= w_wdata;
    end
    if (rd_en) begin
      rd_w_r <= wmem[in_entry_index];
    end
  end

  always_ff @(posedge clk) begin
    if (gc_we) begin
      gcmem[gc_addr] <= gc_wdata;
    end
    if (rd_en) begin
      rd_gc_r <= gcmem[in_entry_index];
    end
  end

  // accumulate with saturation
  always_comb begin
    gsum = {rd_gc_r[63], rd_gc_r[63:32]} + {val_r[31], val_r};
    gsat = gsum[32] != gsum[31];
    if (!gsat) begin
      gnew = gsum[31:0];
    end else if (gsum[32]) begin
      gnew = 32'h8000_0000;
    end else begin
      gnew = 32'h7fff_ffff;
    end
  end

  // cache mix terms
  assign sq_rnd = sq_r + 64'd8388608;
  assign gsq    = sq_rnd[62:24];
  assign dcomp  = 17'd65536 - {1'b0, decay_r};
  assign csum   = sum_r + 58'd32768;

  // sqrt result feeds the divider the same cycle it lands
  assign den        = {1'b0, root} + EPS_Q24;
  assign numer      = {1'b0, num_r} + NUM_W'(den >> 1);
  assign sqrt_start = (state_r == ST_SQRT_GO);
  assign div_start  = (state_r == ST_SQRT_WAIT) && sqrt_done;

  // weight step with signed saturation
  always_comb begin
    delta = neg_r ? (59'd0 - {2'b00, quot}) : {2'b00, quot};
    wsum  = {{27{cur_w_r[31]}}, cur_w_r} + delta;
    wsat  = 1'b0;
    if ($signed(wsum) > $signed(59'sh0_7fff_ffff)) begin
      wnew = 32'h7fff_ffff;
      wsat = 1'b1;
    end else if ($signed(wsum) < -$signed(59'sh0_8000_0000)) begin
      wnew = 32'h8000_0000;
      wsat = 1'b1;
    end else begin
      wnew = wsum[31:0];
    end
  end

  rmsp_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .operand ({cnew_r, 24'd0}),
    .done    (sqrt_done),
    .root    (root)
  );

  rmsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (den),
    .done  (div_done),
    .quot  (quot)
  );

  // next state and memory writes
  always_comb begin
    state_nxt = state_r;
    w_we      = 1'b0;
    w_wdata   = val_r;
    gc_we     = 1'b0;
    gc_addr   = idx_r;
    gc_wdata  = '0;
    unique case (state_r)
      ST_CLEAR: begin
        // sweep zeroes every gradient and cache row
        gc_we   = 1'b1;
        gc_addr = clr_cnt_r;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = in_oor ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        case (cmd_r)
          CMD_LOAD: begin
            w_we      = 1'b1;
            gc_we     = 1'b1;
            state_nxt = ST_OUT;
          end
          CMD_ACCUM: begin
            gc_we     = 1'b1;
            gc_wdata  = {gnew, rd_gc_r[31:0]};
            state_nxt = ST_OUT;
          end
          CMD_UPDATE: state_nxt = ST_SQ;
          default:    state_nxt = ST_OUT;
        endcase
      end
      ST_SQ:        state_nxt = ST_MIX;
      ST_MIX:       state_nxt = ST_CSAT;
      ST_CSAT:      state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          w_we      = 1'b1;
          w_wdata   = wnew;
          gc_we     = 1'b1;
          gc_wdata  = {32'd0, cnew_r};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_r   <= cmd_t'(in_cmd);
          idx_r   <= in_entry_index;
          val_r   <= in_value;
          // out of range entries answer with zeros
          res_w_r <= '0;
          res_c_r <= '0;
          res_s_r <= 1'b0;
        end
      end
      ST_READ: begin
        cur_w_r <= rd_w_r;
        cur_c_r <= rd_gc_r[31:0];
        neg_r   <= rd_gc_r[63];
        mag_r   <= rd_gc_r[63] ? (~rd_gc_r[63:32] + 32'd1) : rd_gc_r[63:32];
        sat_r   <= 1'b0;
        case (cmd_r)
          CMD_LOAD: begin
            res_w_r <= val_r;
            res_c_r <= '0;
            res_s_r <= 1'b0;
          end
          CMD_ACCUM: begin
            res_w_r <= rd_w_r;
            res_c_r <= rd_gc_r[31:0];
            res_s_r <= gsat;
          end
          default: begin
            res_w_r <= rd_w_r;
            res_c_r <= rd_gc_r[31:0];
            res_s_r <= 1'b0;
          end
        endcase
      end
      ST_SQ: begin
        sq_r <= 64'(mag_r) * 64'(mag_r);
      end
      ST_MIX: begin
        sum_r <= 58'(decay_r) * 58'(cur_c_r) + 58'(dcomp) * 58'(gsq);
      end
      ST_CSAT: begin
        // cache clamps at all ones
        if (csum[57:48] != '0) begin
          cnew_r <= 32'hffff_ffff;
          sat_r  <= 1'b1;
        end else begin
          cnew_r <= csum[47:16];
        end
        num_r <= 56'(lr_r) * 56'(mag_r);
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_w_r <= wnew;
          res_c_r <= cnew_r;
          res_s_r <= sat_r || wsat;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_w_r <= res_w_r;
      out_c_r <= res_c_r;
      out_s_r <= res_s_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight_out = out_w_r;
  assign out_cache_out  = out_c_r;
  assign out_saturated  = out_s_r;

endmodule

@@ hdl/rmsp_isqrt.sv @@
// ---------------------------------------------------------------------------
// rmsp_isqrt
// bit-serial integer square root, two operand bits per cycle
// ---------------------------------------------------------------------------
module rmsp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2*rmsp_pkg::ROOT_W-1:0] operand,
  output logic                        done,
  output logic [rmsp_pkg::ROOT_W-1:0] root
);
  import rmsp_pkg::*;

  localparam int OP_W = 2 * ROOT_W;

  logic [OP_W-1:0] x_r;
  logic [OP_W-1:0] r_r;
  logic [OP_W-1:0] bit_r;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [OP_W:0]   trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= operand;
      r_r   <= '0;
      bit_r <= OP_W'(1) << (OP_W - 2);
    end else if (busy_r) begin
      if ({1'b0, x_r} >= trial) begin
        x_r <= OP_W'({1'b0, x_r} - trial);
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

@@ hdl/rmsp_div.sv @@
// ---------------------------------------------------------------------------
// rmsp_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rmsp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rmsp_pkg::NUM_W-1:0] numer,
  input  logic [rmsp_pkg::DEN_W-1:0] denom,
  output logic                       done,
  output logic [rmsp_pkg::NUM_W-1:0] quot
);
  import rmsp_pkg::*;

  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [DEN_W-1:0] rem_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, n_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= numer;
      d_r   <= denom;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, d_r}) : trial[DEN_W-1:0];
      n_r   <= {n_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = n_r;

endmodule

@@ hdl/rmsp_chk.sv @@
// ---------------------------------------------------------------------------
// rmsp_chk
// port-level checker for rmsprop_weight_update, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rmsp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    in_cmd,
  input logic [rmsp_pkg::IDX_W-1:0]    in_entry_index,
  input logic signed [rmsp_pkg::VAL_W-1:0] in_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [rmsp_pkg::VAL_W-1:0] out_weight_out,
  input logic [rmsp_pkg::VAL_W-1:0]    out_cache_out,
  input logic                          out_saturated,
  input logic                          cfg_wr_en,
  input logic                          cfg_index,
  input logic [rmsp_pkg::CFG_W-1:0]    cfg_wdata
);
  import rmsp_pkg::*;

  logic             in_beat, out_beat;
  logic [1:0]       pend_r;
  logic [1:0]       lcmd_r;
  logic [VAL_W-1:0] lval_r;
  logic             lok_r;
  logic             cfg_seen;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;
  assign cfg_seen = cfg_wr_en && (cfg_index || !cfg_index) && (cfg_wdata == cfg_wdata);

  // beats taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_beat) - 2'(out_beat);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      lcmd_r <= in_cmd;
      lval_r <= in_value;
      lok_r  <= 32'(in_entry_index) < ENTRY_COUNT;
    end
  end

  // clearing pass holds the input side off right after reset
  `RMSP_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> in_stall, "no stall after reset")

  // a result never appears without a beat behind it
  `RMSP_ASSERT(a_no_invented, out_valid |-> pend_r != 2'd0, "result without input")

  // load returns the loaded weight and a clean cache
  `RMSP_ASSERT(a_load_echo, out_valid && pend_r == 2'd1 && lok_r && lcmd_r == CMD_LOAD |-> out_weight_out == lval_r && out_cache_out == '0 && !out_saturated, "load result wrong")

  // read never flags saturation
  `RMSP_ASSERT(a_read_nosat, out_valid && pend_r == 2'd1 && lcmd_r == CMD_READ |-> !out_saturated, "read saturated")

  // a stalled result holds
  `RMSP_ASSERT(a_out_hold, out_valid && out_stall && !cfg_seen |=> out_valid && $stable(out_weight_out), "stalled result moved")

endmodule

bind rmsprop_weight_update rmsp_chk u_rmsp_chk (.*);

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// regression for the rmsprop weight update engine: directed corner beats,
// then random load, accumulate, update and read beats across several
// learning rate and decay settings, checked against an in-bench predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rmsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int POOL_SIZE      = 24;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [31:0]        cache;
    logic               sat;
  } result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_cmd;
  logic [IDX_W-1:0] in_entry_index;
  logic signed [VAL_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [VAL_W-1:0] out_weight_out;
  logic [VAL_W-1:0] out_cache_out;
  logic out_saturated;
  logic cfg_wr_en;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  logic signed [31:0] pred_weight [ENTRY_COUNT];
  logic signed [31:0] pred_grad [ENTRY_COUNT];
  logic [31:0]        pred_cache [ENTRY_COUNT];
  logic [23:0]        cur_lr;
  logic [15:0]        cur_decay;

  result_t expected_q[$];
  int  fail_count;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  pool [POOL_SIZE];

  rmsprop_weight_update uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // computes the beat's result and advances the predicted entry
  function automatic result_t apply_command(input cmd_t cmd, input int idx,
                                            input logic signed [31:0] val);
    result_t r;
    logic signed [63:0] sum_s;
    logic [63:0] mag, gsq, mix, c, den, q;
    logic signed [63:0] nw;
    r = '0;
    if (idx >= ENTRY_COUNT) return r;
    case (cmd)
      CMD_LOAD: begin
        pred_weight[idx] = val;
        pred_grad[idx] = '0;
        pred_cache[idx] = '0;
      end
      CMD_ACCUM: begin
        sum_s = 64'(pred_grad[idx]) + 64'(val);
        // gradient saturates to the signed 32-bit range
        if (sum_s > 64'sd2147483647) begin
          sum_s = 64'sd2147483647;
          r.sat = 1'b1;
        end else if (sum_s < -64'sd2147483648) begin
          sum_s = -64'sd2147483648;
          r.sat = 1'b1;
        end
        pred_grad[idx] = sum_s[31:0];
      end
      CMD_UPDATE: begin
        sum_s = 64'(pred_grad[idx]);
        mag = sum_s < 0 ? 64'(-sum_s) : 64'(sum_s);
        gsq = (mag * mag + (64'd1 << 23)) >> 24;
        mix = 64'(cur_decay) * 64'(pred_cache[idx]) + (64'd65536 - cur_decay) * gsq;
        c = (mix + 64'd32768) >> 16;
        // cache clamps at all ones
        if (c > 64'hFFFF_FFFF) begin
          c = 64'hFFFF_FFFF;
          r.sat = 1'b1;
        end
        pred_cache[idx] = c[31:0];
        den = int_sqrt(c << 24) + 64'd168;
        q = (64'(cur_lr) * mag + den / 2) / den;
        nw = 64'(pred_weight[idx]) + (sum_s < 0 ? -$signed(q) : $signed(q));
        if (nw > 64'sd2147483647) begin
          nw = 64'sd2147483647;
          r.sat = 1'b1;
        end else if (nw < -64'sd2147483648) begin
          nw = -64'sd2147483648;
          r.sat = 1'b1;
        end
        pred_weight[idx] = nw[31:0];
        pred_grad[idx] = '0;
      end
      default: ;
    endcase
    r.weight = pred_weight[idx];
    r.cache = pred_cache[idx];
    return r;
  endfunction

  // one input beat, predicted at acceptance; valid stays up until the next
  // idle cycle or the next beat replaces the payload
  task automatic send_beat(input cmd_t cmd, input int idx, input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= idx[IDX_W-1:0];
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, apply_command(cmd, idx, val)};
  endtask

  // waits until idle, then writes one register
  task automatic write_reg(input reg_idx_t ri, input logic [23:0] data);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (ri == REG_LEARN_RATE) cur_lr = data;
    else cur_decay = data[15:0];
  endtask

  // receiver stall, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_weight_out, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_weight_out !== want.weight)
          report_mismatch("weight_out", out_weight_out, want.weight);
        if (out_cache_out !== want.cache)
          report_mismatch("cache_out", out_cache_out, want.cache);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", 32'(out_saturated), 32'(want.sat));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("rmsprop_weight_update regression: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1: return $signed($urandom);
      2: return $signed($urandom) >>> 4;
      default: return $signed($urandom) >>> $urandom_range(20, 8);
    endcase
  endfunction

  // picks an entry that has a weight, or a bad index
  function automatic int rand_loaded_index();
    if ($urandom_range(49) == 0) return $urandom_range(16383, ENTRY_COUNT);
    return pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic test_directed();
    send_beat(CMD_LOAD, 0, 32'sh0100_0000);
    send_beat(CMD_LOAD, ENTRY_COUNT - 1, 32'sh8000_0000);
    send_beat(CMD_READ, 0, 0);
    send_beat(CMD_READ, ENTRY_COUNT - 1, 32'sh7FFF_FFFF);
    // accumulate overflow both ways
    send_beat(CMD_ACCUM, 0, 32'sh7FFF_FFFF);
    send_beat(CMD_ACCUM, 0, 32'sh7FFF_FFFF);
    send_beat(CMD_UPDATE, 0, 0);
    send_beat(CMD_ACCUM, ENTRY_COUNT - 1, 32'sh8000_0000);
    send_beat(CMD_ACCUM, ENTRY_COUNT - 1, 32'sh8000_0000);
    send_beat(CMD_UPDATE, ENTRY_COUNT - 1, 0);
    send_beat(CMD_UPDATE, 0, 0);  // zero gradient
    // weight clamp at the top
    send_beat(CMD_LOAD, 1, 32'sh7FFF_FFF0);
    send_beat(CMD_ACCUM, 1, 32'sh0000_1000);
    send_beat(CMD_UPDATE, 1, 0);
    // out of range index
    send_beat(CMD_LOAD, ENTRY_COUNT, 32'sh1234_5678);
    send_beat(CMD_ACCUM, 16383, 32'sh7FFF_FFFF);
    send_beat(CMD_UPDATE, 16383, 0);
    send_beat(CMD_READ, ENTRY_COUNT, 0);
  endtask

  task automatic test_lr_decay_extremes();
    write_reg(REG_LEARN_RATE, 24'hFF_FFFF);
    write_reg(REG_DECAY, 16'd0);
    send_beat(CMD_LOAD, 2, 0);
    send_beat(CMD_ACCUM, 2, 32'sh7FFF_FFFF);
    send_beat(CMD_UPDATE, 2, 0);  // cache clamp
    send_beat(CMD_ACCUM, 2, -32'sd1);
    send_beat(CMD_UPDATE, 2, 0);
    write_reg(REG_LEARN_RATE, 24'd0);
    write_reg(REG_DECAY, 16'hFFFF);
    send_beat(CMD_ACCUM, 2, 32'sh0100_0000);
    send_beat(CMD_UPDATE, 2, 0);
  endtask

  // accumulate most often, then update, read and load, on a small pool of entries
  task automatic test_random(input int count);
    int n;
    int idx;
    n = 0;
    while (n < count) begin
      idx = rand_loaded_index();
      case ($urandom_range(9))
        0: begin
          idx = $urandom_range(ENTRY_COUNT - 1);
          pool[$urandom_range(POOL_SIZE - 1)] = idx;
          send_beat(CMD_LOAD, idx, rand_value());
        end
        1, 2, 3, 4: send_beat(CMD_ACCUM, idx, rand_value());
        5, 6, 7: send_beat(CMD_UPDATE, idx, rand_value());
        default: send_beat(CMD_READ, idx, rand_value());
      endcase
      n++;
    end
  endtask

  task automatic test_random_phases();
    logic [23:0] lr_set [4] = '{24'd1678, 24'd1, 24'h10_0000, 24'hFF_FFFF};
    logic [15:0] dc_set [4] = '{16'd64881, 16'd0, 16'h8000, 16'hFFFF};
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = (i == 0) ? ENTRY_COUNT - 1 : $urandom_range(ENTRY_COUNT - 1);
      send_beat(CMD_LOAD, pool[i], rand_value());
    end
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_LEARN_RATE, lr_set[p % 4]);
      write_reg(REG_DECAY, dc_set[(p / 4 + p) % 4]);
      if (p == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 13;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random(160);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_entry_index = '0;
    in_value = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_LEARN_RATE;
    cfg_wdata = '0;
    fail_count = 0;
    idle_cycles = 0;
    send_idle_pct = 13;
    recv_idle_pct = 72;
    cur_lr = 24'd1678;
    cur_decay = 16'd64881;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      pred_weight[i] = '0;
      pred_grad[i] = '0;
      pred_cache[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_lr_decay_extremes();
    test_random_phases();

    // drain
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rmsprop_weight_update regression: pass");
    end else begin
      $display("rmsprop_weight_update regression: fail");
    end
    $finish;
  end

endmodule
